// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled by a reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds -> post holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// pre holds -> post holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/uds_pkg.sv =====
// ----------------------------------------------------------------------------
// uds_pkg
// types and constants of the uudecode body stream block
// ----------------------------------------------------------------------------
package uds_pkg;

  localparam int MAX_LINE_BYTES = 45;
  // one buffer row holds the three bytes of a group
  localparam int ROWS   = (MAX_LINE_BYTES + 2) / 3;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_W  = 24;
  localparam int CNT_W  = $clog2(ROWS * 4 + 1);
  localparam int GRP_W  = $clog2(ROWS + 1);
  localparam int LEN_W  = 6;

  localparam logic [GRP_W-1:0] NO_GROUP = '1;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_LEN   = 3'd1;
  localparam logic [2:0] ERR_OVER_MAX  = 3'd2;
  localparam logic [2:0] ERR_BAD_DATA  = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;
  localparam logic [2:0] ERR_NO_TERM   = 3'd5;
  localparam logic [2:0] ERR_NO_END    = 3'd6;
  localparam logic [2:0] ERR_WRONG_END = 3'd7;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TOP   = 8'h60;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_D     = 8'h64;

  // floor(x / 3) as (x * 171) >> 9, exact for x below 512
  localparam logic [13:0] RECIP3    = 14'd171;
  localparam int          RECIP3_SH = 9;

  typedef enum logic [2:0] {
    PH_LSTART,
    PH_BODY,
    PH_ZSKIP,
    PH_ENDLINE,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CR,
    S_RD,
    S_EMIT,
    S_FIN
  } ctl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [2:0] error_code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
    logic [ROW_W-1:0]  data;
  } buf_wr_t;

endpackage

// ===== hdl/uds_in_if.sv =====
// ----------------------------------------------------------------------------
// uds_in_if
// input channel: one stream character or end of stream per transfer
// ----------------------------------------------------------------------------
interface uds_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_in;

  modport source (output valid, output op, output char_in, input ready);
  modport sink (input valid, input op, input char_in, output ready);
endinterface

// ===== hdl/uds_out_if.sv =====
// ----------------------------------------------------------------------------
// uds_out_if
// result channel: decoded byte, finish or error per transfer
// ----------------------------------------------------------------------------
interface uds_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output kind, output data_byte, output error_code,
                  output last, input ready);
  modport sink (input valid, input kind, input data_byte, input error_code,
                input last, output ready);
endinterface

// ===== hdl/uudecode_body_stream_unit.sv =====
// ----------------------------------------------------------------------------
// uudecode_body_stream_unit
// decodes the body of a uuencoded stream, one character per transfer
// ----------------------------------------------------------------------------
// in_chan carries one character (op 0) or end of stream (op 1) per transfer.
// out_chan carries decoded bytes, then a finish or error result; last marks
// the final result caused by one input transfer.
// An ordinary character goes straight into the group decoder. A character
// that follows carriage returns inside a data line is held in S_CR while
// each held return is fed through the group decoder as a data character.
// Decoded groups are written into a line buffer memory, one row per group.
// At a line end the buffer is read back: one row read per group, then
// its bytes one at a time, up to three bytes per row read, then a
// trailing error result if there is one. The first byte passes S_RD, S_EMIT
// and the output register; an early error passes S_FIN and that register.
// Input is held off while a line is drained; a stalled receiver stalls
// the drain, and the result register takes the last result of an item so
// the next item can enter while it waits.
// Reset returns to the start of a data line; the buffer needs no clearing.
// After a finish or error every item is taken and ignored until reset.
`include "assert_macros.svh"

module uudecode_body_stream_unit (
  input logic       clk,
  input logic       rst,
  uds_in_if.sink    in_chan,
  uds_out_if.source out_chan
);
  import uds_pkg::*;

  function automatic logic char_ok(input logic [7:0] c);
    return c inside {[CH_SPACE:CH_TOP]};
  endfunction

  function automatic logic [7:0] end_letter(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = CH_E;
      2'd1:    r = CH_N;
      default: r = CH_D;
    endcase
    return r;
  endfunction

  function automatic logic [GRP_W-1:0] groups_of(input logic [LEN_W-1:0] n);
    logic [13:0] prod;
    prod = (14'(n) + 14'd2) * RECIP3;
    return GRP_W'(prod >> RECIP3_SH);
  endfunction

  function automatic result_t err_res(input logic [2:0] code);
    result_t r;
    r.kind       = KIND_ERR;
    r.data_byte  = 8'd0;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic result_t done_res();
    result_t r;
    r.kind       = KIND_DONE;
    r.data_byte  = 8'd0;
    r.error_code = ERR_NONE;
    r.last       = 1'b1;
    return r;
  endfunction

  phase_t            phase, phase_next;
  ctl_t              ctl, ctl_next;
  logic [LEN_W-1:0]  line_count, line_count_next;
  logic [GRP_W-1:0]  groups, groups_next;
  logic [CNT_W-1:0]  chars_seen, chars_seen_next;
  logic [17:0]       group_chars, group_chars_next;
  logic [GRP_W-1:0]  bad_group, bad_group_next;
  logic [CNT_W-1:0]  pending_cr, pending_cr_next;
  logic [1:0]        end_match, end_match_next;
  logic [7:0]        hold_char, hold_char_next;
  logic [LEN_W-1:0]  emit_cnt, emit_cnt_next;
  logic [LEN_W-1:0]  emit_idx, emit_idx_next;
  logic [ROW_AW-1:0] emit_row, emit_row_next;
  logic [1:0]        emit_sub, emit_sub_next;
  logic              fin_valid, fin_valid_next;
  result_t           fin_res, fin_res_next;

  logic              accept;
  logic [7:0]        c_in;
  logic [CNT_W-1:0]  need;
  logic              short_line;
  logic              has_bad;
  logic [LEN_W-1:0]  line_bytes;
  logic [LEN_W-1:0]  len_val;
  logic              line_end;
  logic              stop_after;
  logic              byte_final;
  logic [7:0]        byte_sel;
  logic [CNT_W:0]    cr_span;

  logic              step_en;
  logic [7:0]        step_c;
  logic [5:0]        step_d;
  logic [CNT_W-1:0]  step_cs;
  logic [17:0]       step_gc;
  logic [GRP_W-1:0]  step_bg;
  buf_wr_t           buf_wr;

  logic              rd_en;
  logic [ROW_W-1:0]  rd_data;
  logic              push;
  result_t           push_res;
  logic              space;

  uds_line_buf u_buf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_en   (rd_en),
    .rd_addr (emit_row),
    .rd_data (rd_data)
  );

  uds_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res      (push_res),
    .space    (space),
    .out_chan (out_chan)
  );

  assign accept     = in_chan.valid && in_chan.ready;
  assign c_in       = in_chan.char_in;
  assign need       = CNT_W'({groups, 2'b00});
  assign short_line = chars_seen < need;
  assign has_bad    = bad_group != NO_GROUP;
  // a bad group stops the line after the groups before it
  assign line_bytes = has_bad ? LEN_W'({bad_group, 1'b0}) + LEN_W'(bad_group) : line_count;
  assign len_val    = c_in[5:0] - 6'd32;
  assign line_end   = (phase == PH_BODY) && (in_chan.op || c_in == CH_NL);
  assign stop_after = has_bad || in_chan.op;
  assign byte_final = LEN_W'(emit_idx + 1'b1) == emit_cnt;
  assign cr_span    = (CNT_W + 1)'(chars_seen) + (CNT_W + 1)'(pending_cr);

  always_comb begin
    case (emit_sub)
      2'd0:    byte_sel = rd_data[23:16];
      2'd1:    byte_sel = rd_data[15:8];
      default: byte_sel = rd_data[7:0];
    endcase
  end

  // group decoder: one data character per cycle
  assign step_d = step_c[5:0] - 6'd32;

  always_comb begin
    step_cs = chars_seen;
    step_gc = group_chars;
    step_bg = bad_group;
    buf_wr  = '0;
    if (step_en && chars_seen < need) begin
      if (!char_ok(step_c) && bad_group == NO_GROUP) begin
        step_bg = GRP_W'(chars_seen >> 2);
      end
      if (chars_seen[1:0] != 2'd3) begin
        step_gc = {group_chars[11:0], step_d};
      end else begin
        // four sextets line up as the three bytes of the row
        buf_wr.en   = 1'b1;
        buf_wr.addr = ROW_AW'(chars_seen >> 2);
        buf_wr.data = {group_chars, step_d};
        step_gc     = '0;
      end
      step_cs = chars_seen + 1'b1;
    end
  end

  // outputs
  always_comb begin
    in_chan.ready = (ctl == S_IDLE);
    step_en       = 1'b0;
    step_c        = hold_char;
    rd_en         = 1'b0;
    push          = 1'b0;
    push_res      = fin_res;
    case (ctl)
      S_IDLE: begin
        if (accept && phase == PH_BODY && !in_chan.op && c_in != CH_NL &&
            c_in != CH_CR && pending_cr == '0) begin
          step_en = 1'b1;
          step_c  = c_in;
        end
      end
      S_CR: begin
        step_en = 1'b1;
        step_c  = (pending_cr != '0) ? CH_CR : hold_char;
      end
      S_RD: begin
        rd_en = 1'b1;
      end
      S_EMIT: begin
        push                = space;
        push_res.kind       = KIND_DATA;
        push_res.data_byte  = byte_sel;
        push_res.error_code = ERR_NONE;
        push_res.last       = byte_final && !fin_valid;
      end
      S_FIN: begin
        push = space;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    phase_next       = phase;
    ctl_next         = ctl;
    line_count_next  = line_count;
    groups_next      = groups;
    chars_seen_next  = step_cs;
    group_chars_next = step_gc;
    bad_group_next   = step_bg;
    pending_cr_next  = pending_cr;
    end_match_next   = end_match;
    hold_char_next   = hold_char;
    emit_cnt_next    = emit_cnt;
    emit_idx_next    = emit_idx;
    emit_row_next    = emit_row;
    emit_sub_next    = emit_sub;
    fin_valid_next   = fin_valid;
    fin_res_next     = fin_res;
    case (ctl)
      S_IDLE: begin
        if (accept && phase != PH_DONE) begin
          if (line_end) begin
            pending_cr_next = '0;
            if (short_line) begin
              fin_valid_next = 1'b1;
              fin_res_next   = err_res(ERR_TRUNC);
              phase_next     = PH_DONE;
              ctl_next       = S_FIN;
            end else begin
              emit_cnt_next  = line_bytes;
              emit_idx_next  = '0;
              emit_row_next  = '0;
              emit_sub_next  = 2'd0;
              fin_valid_next = stop_after;
              fin_res_next   = err_res(has_bad ? ERR_BAD_DATA : ERR_NO_TERM);
              phase_next     = stop_after ? PH_DONE : PH_LSTART;
              // a good line cut off by end of stream drops its bytes
              if ((!in_chan.op || has_bad) && line_bytes != '0) begin
                ctl_next = S_RD;
              end else if (stop_after) begin
                ctl_next = S_FIN;
              end
            end
          end else if (in_chan.op) begin
            fin_valid_next = 1'b1;
            phase_next     = PH_DONE;
            ctl_next       = S_FIN;
            case (phase)
              PH_LSTART: fin_res_next = err_res(ERR_NO_TERM);
              PH_ZSKIP:  fin_res_next = err_res(ERR_NO_END);
              default: begin
                if (end_match == 2'd0 && pending_cr == '0) begin
                  fin_res_next = err_res(ERR_NO_END);
                end else if (end_match == 2'd3) begin
                  fin_res_next = done_res();
                end else begin
                  fin_res_next = err_res(ERR_WRONG_END);
                end
              end
            endcase
          end else if (c_in == CH_NL) begin
            case (phase)
              PH_LSTART: pending_cr_next = '0;
              PH_ZSKIP: begin
                phase_next      = PH_ENDLINE;
                end_match_next  = 2'd0;
                pending_cr_next = '0;
              end
              default: begin
                fin_valid_next = 1'b1;
                fin_res_next   = (end_match == 2'd3) ? done_res() : err_res(ERR_WRONG_END);
                phase_next     = PH_DONE;
                ctl_next       = S_FIN;
              end
            endcase
          end else if (c_in == CH_CR) begin
            case (phase)
              PH_BODY: begin
                if (pending_cr < need - chars_seen) begin
                  pending_cr_next = pending_cr + 1'b1;
                end
              end
              PH_ZSKIP: ;
              default: pending_cr_next = CNT_W'(1);
            endcase
          end else begin
            case (phase)
              PH_LSTART: begin
                if (pending_cr != '0 || !char_ok(c_in)) begin
                  fin_valid_next = 1'b1;
                  fin_res_next   = err_res(ERR_BAD_LEN);
                  phase_next     = PH_DONE;
                  ctl_next       = S_FIN;
                end else if (len_val == '0) begin
                  phase_next = PH_ZSKIP;
                end else if (len_val > LEN_W'(MAX_LINE_BYTES)) begin
                  fin_valid_next = 1'b1;
                  fin_res_next   = err_res(ERR_OVER_MAX);
                  phase_next     = PH_DONE;
                  ctl_next       = S_FIN;
                end else begin
                  line_count_next  = len_val;
                  groups_next      = groups_of(len_val);
                  chars_seen_next  = '0;
                  group_chars_next = '0;
                  bad_group_next   = NO_GROUP;
                  pending_cr_next  = '0;
                  phase_next       = PH_BODY;
                end
              end
              PH_BODY: begin
                // held returns become data characters ahead of this one
                if (pending_cr != '0) begin
                  hold_char_next = c_in;
                  ctl_next       = S_CR;
                end
              end
              PH_ENDLINE: begin
                if (pending_cr != '0 || end_match == 2'd3 ||
                    c_in != end_letter(end_match)) begin
                  fin_valid_next = 1'b1;
                  fin_res_next   = err_res(ERR_WRONG_END);
                  phase_next     = PH_DONE;
                  ctl_next       = S_FIN;
                end else begin
                  end_match_next = end_match + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_CR: begin
        if (pending_cr != '0) begin
          pending_cr_next = pending_cr - 1'b1;
        end else begin
          ctl_next = S_IDLE;
        end
      end
      S_RD: begin
        ctl_next = S_EMIT;
      end
      S_EMIT: begin
        if (space) begin
          emit_idx_next = emit_idx + 1'b1;
          if (byte_final) begin
            ctl_next = fin_valid ? S_FIN : S_IDLE;
          end else if (emit_sub == 2'd2) begin
            emit_sub_next = 2'd0;
            emit_row_next = emit_row + 1'b1;
            ctl_next      = S_RD;
          end else begin
            emit_sub_next = emit_sub + 1'b1;
          end
        end
      end
      S_FIN: begin
        if (space) begin
          fin_valid_next = 1'b0;
          ctl_next       = S_IDLE;
        end
      end
      default: ctl_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LSTART;
      ctl         <= S_IDLE;
      line_count  <= '0;
      groups      <= '0;
      chars_seen  <= '0;
      group_chars <= '0;
      bad_group   <= NO_GROUP;
      pending_cr  <= '0;
      end_match   <= 2'd0;
      emit_cnt    <= '0;
      emit_idx    <= '0;
      emit_row    <= '0;
      emit_sub    <= 2'd0;
      fin_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      ctl         <= ctl_next;
      line_count  <= line_count_next;
      groups      <= groups_next;
      chars_seen  <= chars_seen_next;
      group_chars <= group_chars_next;
      bad_group   <= bad_group_next;
      pending_cr  <= pending_cr_next;
      end_match   <= end_match_next;
      emit_cnt    <= emit_cnt_next;
      emit_idx    <= emit_idx_next;
      emit_row    <= emit_row_next;
      emit_sub    <= emit_sub_next;
      fin_valid   <= fin_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hold_char <= hold_char_next;
    fin_res   <= fin_res_next;
  end

  `ASSERT_NEXT(a_done_sticky, clk, rst, phase == PH_DONE, phase == PH_DONE)
  `ASSERT_IMPLIES(a_emit_in_range, clk, rst, ctl == S_EMIT, emit_idx < emit_cnt)
  `ASSERT_IMPLIES(a_wr_in_body, clk, rst, buf_wr.en, phase == PH_BODY)
  `ASSERT_IMPLIES(a_cr_room, clk, rst, phase == PH_BODY, cr_span <= (CNT_W + 1)'(need))

endmodule

// ===== hdl/uds_line_buf.sv =====
// ----------------------------------------------------------------------------
// uds_line_buf
// line byte buffer, one row of three decoded bytes per group, registered read
// ----------------------------------------------------------------------------
module uds_line_buf (
  input  logic                      clk,
  input  uds_pkg::buf_wr_t          wr,
  input  logic                      rd_en,
  input  logic [uds_pkg::ROW_AW-1:0] rd_addr,
  output logic [uds_pkg::ROW_W-1:0]  rd_data
);
  import uds_pkg::*;

  logic [ROW_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/uds_out_stage.sv =====
// ----------------------------------------------------------------------------
// uds_out_stage
// output register between the sequencer and the result channel
// ----------------------------------------------------------------------------
module uds_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  uds_pkg::result_t res,
  output logic             space,
  uds_out_if.source        out_chan
);
  import uds_pkg::*;

  logic    valid;
  result_t hold;

  assign space = !valid || out_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (out_chan.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hold <= res;
    end
  end

  assign out_chan.valid      = valid;
  assign out_chan.kind       = hold.kind;
  assign out_chan.data_byte  = hold.data_byte;
  assign out_chan.error_code = hold.error_code;
  assign out_chan.last       = hold.last;

endmodule

// ===== tb/sv/uds_checker.sv =====
// ----------------------------------------------------------------------------
// uds_checker
// watches both channels of the uudecode body stream block, predicts the
// results of every accepted character and compares them in order
// ----------------------------------------------------------------------------
module uds_checker (
  input  logic clk,
  input  logic rst,
  uds_in_if    in_chan,
  uds_out_if   out_chan,
  output int   fail_count,
  output int   pending,
  output int   checked
);
  import uds_pkg::*;

  // decoder state as the block should hold it
  phase_t      dec_phase;
  int          line_n;
  int          chars_got;
  int          bad_grp;     // -1 while every group of the line is clean
  int          cr_held;
  int          end_idx;
  logic [17:0] group_acc;
  logic [7:0]  line_bytes [MAX_LINE_BYTES];

  result_t     uu_results[$];

  function automatic int chars_needed();
    return (line_n + 2) / 3 * 4;
  endfunction

  function automatic void add_result(logic [1:0] k, logic [7:0] b, logic [2:0] e);
    result_t r;
    r.kind       = k;
    r.data_byte  = b;
    r.error_code = e;
    r.last       = 1'b0;
    uu_results.push_back(r);
  endfunction

  function automatic void stop_with(logic [2:0] e);
    add_result(KIND_ERR, 8'h00, e);
    dec_phase = PH_DONE;
  endfunction

  function automatic void feed_data(logic [7:0] c);
    int         pos;
    int         g;
    logic [7:0] t;
    logic [5:0] d;
    logic [5:0] d1;
    logic [5:0] d2;
    logic [5:0] d3;
    logic [7:0] b [3];
    pos = chars_got;
    if (pos >= chars_needed()) return;
    t = c - CH_SPACE;
    d = t[5:0];
    g = pos / 4;
    if ((c < CH_SPACE || c > CH_TOP) && bad_grp < 0) bad_grp = g;
    if (pos % 4 < 3) begin
      group_acc = {group_acc[11:0], d};
    end else begin
      d1 = group_acc[17:12];
      d2 = group_acc[11:6];
      d3 = group_acc[5:0];
      b[0] = {d1, d2[5:4]};
      b[1] = {d2[3:0], d3[5:2]};
      b[2] = {d3[1:0], d};
      for (int j = 0; j < 3; j++) begin
        if (g * 3 + j < MAX_LINE_BYTES) line_bytes[g * 3 + j] = b[j];
      end
      group_acc = '0;
    end
    chars_got = pos + 1;
  endfunction

  function automatic void close_line(logic at_eof);
    int cnt;
    cr_held = 0;
    if (chars_got < chars_needed()) begin
      stop_with(ERR_TRUNC);
      return;
    end
    cnt = line_n;
    if (bad_grp >= 0 && 3 * bad_grp < cnt) cnt = 3 * bad_grp;
    if (cnt > MAX_LINE_BYTES) cnt = MAX_LINE_BYTES;
    // a good line cut off by end of stream loses its bytes
    if (!at_eof || bad_grp >= 0) begin
      for (int i = 0; i < cnt; i++) add_result(KIND_DATA, line_bytes[i], ERR_NONE);
    end
    if (bad_grp >= 0) stop_with(ERR_BAD_DATA);
    else if (at_eof) stop_with(ERR_NO_TERM);
    else dec_phase = PH_LSTART;
  endfunction

  function automatic void take_len(logic [7:0] c);
    logic [7:0] t;
    int         n;
    t = c - CH_SPACE;
    n = int'(t[5:0]);
    if (c < CH_SPACE || c > CH_TOP) begin
      stop_with(ERR_BAD_LEN);
      return;
    end
    if (n == 0) begin
      dec_phase = PH_ZSKIP;
      return;
    end
    if (n > MAX_LINE_BYTES) begin
      stop_with(ERR_OVER_MAX);
      return;
    end
    line_n    = n;
    chars_got = 0;
    group_acc = '0;
    bad_grp   = -1;
    cr_held   = 0;
    dec_phase = PH_BODY;
  endfunction

  function automatic void take_end(logic [7:0] c);
    logic [7:0] want_c;
    case (end_idx)
      0:       want_c = CH_E;
      1:       want_c = CH_N;
      2:       want_c = CH_D;
      default: want_c = 8'h00;
    endcase
    if (cr_held != 0 || end_idx >= 3 || c != want_c) stop_with(ERR_WRONG_END);
    else end_idx++;
  endfunction

  function automatic void decode_item(logic eos, logic [7:0] c);
    int      first;
    result_t r;
    first = uu_results.size();
    if (dec_phase == PH_DONE) return;
    if (eos) begin
      case (dec_phase)
        PH_LSTART: stop_with(ERR_NO_TERM);
        PH_BODY:   close_line(1'b1);
        PH_ZSKIP:  stop_with(ERR_NO_END);
        PH_ENDLINE: begin
          if (end_idx == 0 && cr_held == 0) stop_with(ERR_NO_END);
          else if (end_idx == 3) add_result(KIND_DONE, 8'h00, ERR_NONE);
          else stop_with(ERR_WRONG_END);
        end
        default: ;
      endcase
      dec_phase = PH_DONE;
    end else if (c == CH_NL) begin
      case (dec_phase)
        PH_LSTART: cr_held = 0;
        PH_BODY:   close_line(1'b0);
        PH_ZSKIP: begin
          dec_phase = PH_ENDLINE;
          end_idx   = 0;
          cr_held   = 0;
        end
        PH_ENDLINE: begin
          if (end_idx == 3) begin
            add_result(KIND_DONE, 8'h00, ERR_NONE);
            dec_phase = PH_DONE;
          end else begin
            stop_with(ERR_WRONG_END);
          end
        end
        default: ;
      endcase
    end else if (c == CH_CR) begin
      // inside a data line, returns are held only up to the data still owed by the line
      if (dec_phase == PH_BODY) begin
        if (cr_held < chars_needed() - chars_got) cr_held++;
      end else if (dec_phase != PH_ZSKIP) begin
        cr_held = 1;
      end
    end else begin
      case (dec_phase)
        PH_LSTART: begin
          if (cr_held != 0) stop_with(ERR_BAD_LEN);
          else take_len(c);
        end
        PH_BODY: begin
          repeat (cr_held) feed_data(CH_CR);
          cr_held = 0;
          feed_data(c);
        end
        PH_ENDLINE: take_end(c);
        default: ;
      endcase
    end
    if (uu_results.size() > first) begin
      r = uu_results.pop_back();
      r.last = 1'b1;
      uu_results.push_back(r);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      dec_phase = PH_LSTART;
      line_n    = 0;
      chars_got = 0;
      group_acc = '0;
      bad_grp   = -1;
      cr_held   = 0;
      end_idx   = 0;
      uu_results.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.kind       = out_chan.kind;
        got.data_byte  = out_chan.data_byte;
        got.error_code = out_chan.error_code;
        got.last       = out_chan.last;
        if (uu_results.size() == 0) begin
          $display("%0t: unexpected result: kind %0d byte %02h code %0d last %0d",
                   $time, got.kind, got.data_byte, got.error_code, got.last);
          fail_count++;
        end else begin
          want = uu_results.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.error_code !== want.error_code || got.last !== want.last) begin
            $display("%0t: mismatch: expected kind %0d byte %02h code %0d last %0d, actual kind %0d byte %02h code %0d last %0d",
                     $time, want.kind, want.data_byte, want.error_code, want.last,
                     got.kind, got.data_byte, got.error_code, got.last);
            fail_count++;
          end
          checked++;
        end
      end
      if (in_chan.valid && in_chan.ready) decode_item(in_chan.op, in_chan.char_in);
    end
    pending = uu_results.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives one long uuencoded body through the decoder: a few hand-picked lines,
// then random lines, then one randomly chosen ending, clean or broken
// ----------------------------------------------------------------------------
module tb_top;
  import uds_pkg::*;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } stream_item_t;

  logic         clk;
  logic         rst;
  logic         rx_ready = 1'b0;
  int           stall_pct = 0;
  int           fail_count;
  int           pending;
  int           checked;
  int           line_total = 0;
  string        ending;
  stream_item_t body_q[$];

  uds_in_if  in_chan ();
  uds_out_if out_chan ();

  assign out_chan.ready = rx_ready;

  uudecode_body_stream_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  uds_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    rx_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void put_item(logic op, logic [7:0] ch);
    stream_item_t it;
    it.op = op;
    it.ch = ch;
    body_q.push_back(it);
  endfunction

  function automatic logic [7:0] alpha_char();
    int v;
    v = $urandom_range(CH_TOP, CH_SPACE);
    return v[7:0];
  endfunction

  // anything but a newline
  function automatic logic [7:0] junk_char();
    int v;
    v = $urandom_range(255);
    if (v == CH_NL) v = 255;
    return v[7:0];
  endfunction

  // outside the alphabet, and neither newline nor return
  function automatic logic [7:0] bad_char();
    int v;
    if ($urandom_range(1) == 1) begin
      v = $urandom_range(255, 8'h61);
    end else begin
      v = $urandom_range(31);
      if (v == CH_NL || v == CH_CR) v = 0;
    end
    return v[7:0];
  endfunction

  function automatic void put_len(int n);
    logic [7:0] c;
    c = CH_SPACE + n[7:0];
    put_item(OP_CHAR, c);
  endfunction

  function automatic void put_line(int n, int extra, int crs);
    put_len(n);
    for (int i = 0; i < (n + 2) / 3 * 4; i++) put_item(OP_CHAR, alpha_char());
    repeat (extra) put_item(OP_CHAR, junk_char());
    repeat (crs) put_item(OP_CHAR, CH_CR);
    put_item(OP_CHAR, CH_NL);
    line_total++;
  endfunction

  function automatic void put_zero_line();
    put_item(OP_CHAR, ($urandom_range(1) == 1) ? CH_TOP : CH_SPACE);
    repeat ($urandom_range(3)) put_item(OP_CHAR, junk_char());
  endfunction

  function automatic void put_ending(int sel);
    int         n;
    int         need;
    int         k;
    int         v;
    logic [7:0] lo;
    case (sel)
      4: begin
        ending = "bad length character";
        if ($urandom_range(2) == 0) begin
          put_item(OP_CHAR, CH_CR);
          put_item(OP_CHAR, alpha_char());
        end else begin
          put_item(OP_CHAR, bad_char());
        end
      end
      5: begin
        ending = "length over maximum";
        lo = 8'(CH_SPACE + MAX_LINE_BYTES + 1);
        v = $urandom_range(8'h5f, lo);
        put_item(OP_CHAR, v[7:0]);
      end
      6: begin
        ending = "bad data character";
        n = $urandom_range(12, 1);
        need = (n + 2) / 3 * 4;
        k = $urandom_range(need - 1);
        put_len(n);
        for (int i = 0; i < need; i++) begin
          if (i != k) put_item(OP_CHAR, alpha_char());
          // a return inside the data turns into a bad character
          else if (k < need - 1 && $urandom_range(1) == 1) put_item(OP_CHAR, CH_CR);
          else put_item(OP_CHAR, bad_char());
        end
        if ($urandom_range(3) == 0) put_item(OP_EOS, junk_char());
        else put_item(OP_CHAR, CH_NL);
      end
      7: begin
        ending = "truncated line";
        n = $urandom_range(12, 1);
        need = (n + 2) / 3 * 4;
        put_len(n);
        repeat ($urandom_range(need - 1)) put_item(OP_CHAR, alpha_char());
        if ($urandom_range(3) == 0) put_item(OP_EOS, junk_char());
        else put_item(OP_CHAR, CH_NL);
      end
      8: begin
        ending = "no terminator line";
        v = $urandom_range(2);
        if (v == 1) begin
          n = $urandom_range(12, 1);
          put_len(n);
          repeat ((n + 2) / 3 * 4) put_item(OP_CHAR, alpha_char());
        end else if (v == 2) begin
          put_item(OP_CHAR, CH_CR);
        end
        put_item(OP_EOS, junk_char());
      end
      9: begin
        ending = "no end line";
        put_zero_line();
        if ($urandom_range(1) == 1) put_item(OP_CHAR, CH_NL);
        put_item(OP_EOS, junk_char());
      end
      10: begin
        ending = "wrong end line";
        put_zero_line();
        put_item(OP_CHAR, CH_NL);
        case ($urandom_range(5))
          0: begin
            put_item(OP_CHAR, CH_E);
            put_item(OP_CHAR, CH_N);
            put_item(OP_CHAR, CH_NL);
          end
          1: begin
            put_item(OP_CHAR, CH_E);
            put_item(OP_CHAR, 8'h78);
          end
          2: begin
            put_item(OP_CHAR, CH_E);
            put_item(OP_CHAR, CH_N);
            put_item(OP_CHAR, CH_D);
            put_item(OP_CHAR, CH_D);
          end
          3: begin
            put_item(OP_CHAR, CH_CR);
            put_item(OP_CHAR, CH_E);
          end
          4: begin
            put_item(OP_CHAR, CH_E);
            put_item(OP_EOS, junk_char());
          end
          default: begin
            put_item(OP_CHAR, CH_CR);
            put_item(OP_EOS, junk_char());
          end
        endcase
      end
      default: begin
        ending = "clean end line";
        put_zero_line();
        put_item(OP_CHAR, CH_NL);
        put_item(OP_CHAR, CH_E);
        put_item(OP_CHAR, CH_N);
        put_item(OP_CHAR, CH_D);
        v = $urandom_range(3);
        if (v == 1 || v == 3) put_item(OP_CHAR, CH_CR);
        if (v < 2) put_item(OP_CHAR, CH_NL);
        else put_item(OP_EOS, junk_char());
      end
    endcase
  endfunction

  task automatic send_item(stream_item_t it, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.op      <= it.op;
    in_chan.char_in <= it.ch;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int n;
    int third;
    int idle_pct;
    int w;
    rst             = 1'b1;
    in_chan.valid   = 1'b0;
    in_chan.op      = OP_CHAR;
    in_chan.char_in = 8'h00;

    // hand-picked lines: one byte of all ones, blank lines, zero bytes with
    // both spellings of zero, returns and a high byte after complete data
    put_len(1);
    repeat (4) put_item(OP_CHAR, 8'h5f);
    put_item(OP_CHAR, CH_NL);
    put_item(OP_CHAR, CH_NL);
    put_item(OP_CHAR, CH_CR);
    put_item(OP_CHAR, CH_CR);
    put_item(OP_CHAR, CH_NL);
    put_len(3);
    put_item(OP_CHAR, CH_TOP);
    put_item(OP_CHAR, CH_SPACE);
    put_item(OP_CHAR, CH_TOP);
    put_item(OP_CHAR, CH_SPACE);
    put_item(OP_CHAR, CH_CR);
    put_item(OP_CHAR, 8'hff);
    put_item(OP_CHAR, CH_CR);
    put_item(OP_CHAR, CH_NL);
    line_total += 2;
    put_line(2, 0, 0);

    // random well-formed lines, mostly short
    while (body_q.size() < 400) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(2)) put_item(OP_CHAR, CH_CR);
        put_item(OP_CHAR, CH_NL);
      end else begin
        if (line_total == 8) n = MAX_LINE_BYTES;
        else if ($urandom_range(3) == 0) n = $urandom_range(MAX_LINE_BYTES, 13);
        else n = $urandom_range(12, 1);
        put_line(n, ($urandom_range(4) == 0) ? $urandom_range(4, 1) : 0,
                 ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0);
      end
    end
    put_ending($urandom_range(11));
    // the block is finished by now and must ignore these
    repeat (6) put_item(1'($urandom_range(1)), 8'($urandom_range(255)));

    third = body_q.size() / 3;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < body_q.size(); i++) begin
      if (i == third || i == 2 * third) begin
        // hold off until the decoder has delivered everything
        in_chan.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      if (i < third) begin
        idle_pct  = 25;
        stall_pct = 88;
      end else if (i < 2 * third) begin
        idle_pct  = 88;
        stall_pct = 25;
      end else begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      send_item(body_q[i], idle_pct);
    end
    in_chan.valid <= 1'b0;

    for (w = 0; w < 50000 && pending != 0; w++) @(negedge clk);
    repeat (100) @(negedge clk);

    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    $display("covered %0d stream characters in %0d data lines, %0d results checked",
             body_q.size(), line_total, checked);
    $display("stream ended by: %s", ending);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: run did not finish in time", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
